// ===== rtl/clpc_pkg.sv =====
// Shared constants, types and the init byte table of the character LCD bus controller.
package clpc_pkg;

	// Width of the saturating tick counter (supported range 18 to 32).
	localparam int DelayBits = 20;
	localparam int WaitW     = 20;
	localparam int TimeW     = 8;
	localparam int StepW     = 4;
	localparam int CfgIdxW   = 4;
	localparam int CfgDataW  = 20;
	localparam int OpW       = 2;
	localparam int ByteW     = 8;
	localparam int CmpW      = (DelayBits > WaitW) ? DelayBits : WaitW;

	// Item operations
	localparam logic [OpW-1:0] OP_TICK    = 2'd0;
	localparam logic [OpW-1:0] OP_CHAR    = 2'd1;
	localparam logic [OpW-1:0] OP_RESTART = 2'd2;

	// Sequence steps: power-up wait, eight init commands, idle, character write
	localparam logic [StepW-1:0] STEP_POWER    = 4'd0;
	localparam logic [StepW-1:0] STEP_FIRST    = 4'd1;
	localparam logic [StepW-1:0] STEP_SECOND   = 4'd2;
	localparam logic [StepW-1:0] STEP_THIRD    = 4'd3;
	localparam logic [StepW-1:0] STEP_FUNCTION = 4'd4;
	localparam logic [StepW-1:0] STEP_DISPLAY  = 4'd5;
	localparam logic [StepW-1:0] STEP_CLEAR    = 4'd6;
	localparam logic [StepW-1:0] STEP_ENTRY    = 4'd7;
	localparam logic [StepW-1:0] STEP_CURSOR   = 4'd8;
	localparam logic [StepW-1:0] STEP_IDLE     = 4'd9;
	localparam logic [StepW-1:0] STEP_CHAR     = 4'd10;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_SETUP        = 4'd0;
	localparam logic [CfgIdxW-1:0] REG_PULSE        = 4'd1;
	localparam logic [CfgIdxW-1:0] REG_HOLD         = 4'd2;
	localparam logic [CfgIdxW-1:0] REG_POWER_UP     = 4'd3;
	localparam logic [CfgIdxW-1:0] REG_FIRST_WAIT   = 4'd4;
	localparam logic [CfgIdxW-1:0] REG_SECOND_WAIT  = 4'd5;
	localparam logic [CfgIdxW-1:0] REG_COMMAND_WAIT = 4'd6;
	localparam logic [CfgIdxW-1:0] REG_CLEAR_WAIT   = 4'd7;

	// Init command bytes
	localparam logic [ByteW-1:0] CMD_WAKE     = 8'h30;
	localparam logic [ByteW-1:0] CMD_FUNCTION = 8'h3C;
	localparam logic [ByteW-1:0] CMD_DISPLAY  = 8'h0E;
	localparam logic [ByteW-1:0] CMD_CLEAR    = 8'h01;
	localparam logic [ByteW-1:0] CMD_ENTRY    = 8'h05;
	localparam logic [ByteW-1:0] CMD_SHIFT    = 8'h18;

	typedef enum logic [3:0] {
		PH_SETUP = 4'b0001,
		PH_PULSE = 4'b0010,
		PH_HOLD  = 4'b0100,
		PH_WAIT  = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [TimeW-1:0] setup_ticks;
		logic [TimeW-1:0] pulse_ticks;
		logic [TimeW-1:0] hold_ticks;
		logic [WaitW-1:0] power_up_ticks;
		logic [WaitW-1:0] first_wait_ticks;
		logic [WaitW-1:0] second_wait_ticks;
		logic [WaitW-1:0] command_wait_ticks;
		logic [WaitW-1:0] clear_wait_ticks;
	} cfg_t;

	typedef struct packed {
		logic             lcd_rs;
		logic             lcd_enable;
		logic [ByteW-1:0] lcd_data;
		logic             busy_res;
		logic             ready_res;
		logic             accepted;
	} result_t;

	function automatic logic [ByteW-1:0] init_byte(input logic [StepW-1:0] step);
		logic [ByteW-1:0] b;
		case (step)
			STEP_FIRST, STEP_SECOND, STEP_THIRD: b = CMD_WAKE;
			STEP_FUNCTION:                       b = CMD_FUNCTION;
			STEP_DISPLAY:                        b = CMD_DISPLAY;
			STEP_CLEAR:                          b = CMD_CLEAR;
			STEP_ENTRY:                          b = CMD_ENTRY;
			STEP_CURSOR:                         b = CMD_SHIFT;
			default:                             b = '0;
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/clpc_item_if.sv =====
// Channel interfaces: input items, result items and configuration writes.
interface clpc_item_if;
	logic                         valid;
	logic                         ready;
	logic [clpc_pkg::OpW-1:0]     op;
	logic [clpc_pkg::ByteW-1:0]   char_code;
	modport source (output valid, op, char_code, input ready);
	modport sink   (input valid, op, char_code, output ready);
endinterface

interface clpc_result_if;
	logic                         valid;
	logic                         ready;
	logic                         lcd_rs;
	logic                         lcd_enable;
	logic [clpc_pkg::ByteW-1:0]   lcd_data;
	logic                         busy_res;
	logic                         ready_res;
	logic                         accepted;
	modport source (output valid, lcd_rs, lcd_enable, lcd_data, busy_res, ready_res, accepted,
		input ready);
	modport sink   (input valid, lcd_rs, lcd_enable, lcd_data, busy_res, ready_res, accepted,
		output ready);
endinterface

interface clpc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [clpc_pkg::CfgIdxW-1:0]    index;
	logic [clpc_pkg::CfgDataW-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/clpc_cfg_regs.sv =====
// Timing configuration register file.
module clpc_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	clpc_cfg_if.sink           cfg,
	output clpc_pkg::cfg_t     regs
);

	clpc_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.setup_ticks        <= 8'd1;
			regs_q.pulse_ticks        <= 8'd2;
			regs_q.hold_ticks         <= 8'd1;
			regs_q.power_up_ticks     <= 20'd240000;
			regs_q.first_wait_ticks   <= 20'd65600;
			regs_q.second_wait_ticks  <= 20'd1600;
			regs_q.command_wait_ticks <= 20'd624;
			regs_q.clear_wait_ticks   <= 20'd25320;
		end else if (cfg.valid) begin
			case (cfg.index)
				clpc_pkg::REG_SETUP:        regs_q.setup_ticks        <= cfg.data[7:0];
				clpc_pkg::REG_PULSE:        regs_q.pulse_ticks        <= cfg.data[7:0];
				clpc_pkg::REG_HOLD:         regs_q.hold_ticks         <= cfg.data[7:0];
				clpc_pkg::REG_POWER_UP:     regs_q.power_up_ticks     <= cfg.data;
				clpc_pkg::REG_FIRST_WAIT:   regs_q.first_wait_ticks   <= cfg.data;
				clpc_pkg::REG_SECOND_WAIT:  regs_q.second_wait_ticks  <= cfg.data;
				clpc_pkg::REG_COMMAND_WAIT: regs_q.command_wait_ticks <= cfg.data;
				clpc_pkg::REG_CLEAR_WAIT:   regs_q.clear_wait_ticks   <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/clpc_seq.sv =====
// Init and transfer sequencer: state registers and per-item next-state logic.
module clpc_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  logic [clpc_pkg::OpW-1:0]      op,
	input  logic [clpc_pkg::ByteW-1:0]    char_code,
	input  clpc_pkg::cfg_t                regs,
	output clpc_pkg::result_t             res
);

	localparam int DW = clpc_pkg::DelayBits;
	localparam int CW = clpc_pkg::CmpW;

	logic [clpc_pkg::StepW-1:0] step_q, step_n;
	clpc_pkg::phase_t           phase_q, phase_n;
	logic [DW-1:0]              cnt_q, cnt_n, cnt_inc;
	logic [clpc_pkg::ByteW-1:0] pend_q, pend_n, bus_q, bus_n;
	logic                       rs_q, rs_n, en_q, en_n, done_q, done_n;
	logic                       acc;
	logic [clpc_pkg::WaitW-1:0] len_raw, wait_len;
	logic [CW-1:0]              len_x, cmax_x, len_c;
	logic                       ticking, phase_end;

	// Wait after the current command
	always_comb begin
		case (step_q)
			clpc_pkg::STEP_FIRST:  wait_len = regs.first_wait_ticks;
			clpc_pkg::STEP_SECOND: wait_len = regs.second_wait_ticks;
			clpc_pkg::STEP_CLEAR:  wait_len = regs.clear_wait_ticks;
			default:               wait_len = regs.command_wait_ticks;
		endcase
	end

	always_comb begin
		if (step_q == clpc_pkg::STEP_POWER) begin
			len_raw = regs.power_up_ticks;
		end else begin
			case (phase_q)
				clpc_pkg::PH_SETUP: len_raw = clpc_pkg::WaitW'(regs.setup_ticks);
				clpc_pkg::PH_PULSE: len_raw = clpc_pkg::WaitW'(regs.pulse_ticks);
				clpc_pkg::PH_HOLD:  len_raw = clpc_pkg::WaitW'(regs.hold_ticks);
				default:            len_raw = wait_len;
			endcase
		end
	end

	// Saturating count and clamped length compare
	assign cnt_inc   = (cnt_q == {DW{1'b1}}) ? cnt_q : cnt_q + 1'b1;
	assign len_x     = CW'(len_raw);
	assign cmax_x    = CW'({DW{1'b1}});
	assign len_c     = (len_x > cmax_x) ? cmax_x : len_x;
	assign phase_end = CW'(cnt_inc) >= len_c;
	assign ticking   = (op == clpc_pkg::OP_TICK) && (step_q != clpc_pkg::STEP_IDLE)
		&& (step_q <= clpc_pkg::STEP_CHAR);

	always_comb begin
		step_n  = step_q;
		phase_n = phase_q;
		cnt_n   = cnt_q;
		pend_n  = pend_q;
		rs_n    = rs_q;
		en_n    = en_q;
		bus_n   = bus_q;
		done_n  = done_q;
		acc     = 1'b0;
		if (ticking) begin
			cnt_n = cnt_inc;
			if (phase_end) begin
				cnt_n = '0;
				if (step_q == clpc_pkg::STEP_POWER) begin
					step_n  = clpc_pkg::STEP_FIRST;
					phase_n = clpc_pkg::PH_SETUP;
					rs_n    = 1'b0;
					en_n    = 1'b0;
					bus_n   = '0;
				end else begin
					case (phase_q)
						clpc_pkg::PH_SETUP: begin
							phase_n = clpc_pkg::PH_PULSE;
							en_n    = 1'b1;
							bus_n   = (step_q == clpc_pkg::STEP_CHAR) ? pend_q
								: clpc_pkg::init_byte(step_q);
						end
						clpc_pkg::PH_PULSE: begin
							phase_n = clpc_pkg::PH_HOLD;
							en_n    = 1'b0;
						end
						clpc_pkg::PH_HOLD: begin
							phase_n = clpc_pkg::PH_WAIT;
							bus_n   = '0;
						end
						default: begin
							if (step_q >= clpc_pkg::STEP_CURSOR) begin
								if (step_q == clpc_pkg::STEP_CURSOR) begin
									done_n = 1'b1;
								end
								step_n  = clpc_pkg::STEP_IDLE;
								phase_n = clpc_pkg::PH_SETUP;
							end else begin
								step_n  = step_q + 1'b1;
								phase_n = clpc_pkg::PH_SETUP;
								rs_n    = 1'b0;
								en_n    = 1'b0;
								bus_n   = '0;
							end
						end
					endcase
				end
			end
		end else if (op == clpc_pkg::OP_CHAR) begin
			if (step_q == clpc_pkg::STEP_IDLE && done_q) begin
				pend_n  = char_code;
				step_n  = clpc_pkg::STEP_CHAR;
				phase_n = clpc_pkg::PH_SETUP;
				cnt_n   = '0;
				rs_n    = 1'b1;
				en_n    = 1'b0;
				bus_n   = '0;
				acc     = 1'b1;
			end
		end else if (op == clpc_pkg::OP_RESTART) begin
			step_n  = clpc_pkg::STEP_POWER;
			phase_n = clpc_pkg::PH_SETUP;
			cnt_n   = '0;
			rs_n    = 1'b0;
			en_n    = 1'b0;
			bus_n   = '0;
			done_n  = 1'b0;
			acc     = 1'b1;
		end
	end

	always_comb begin
		res.lcd_rs     = rs_n;
		res.lcd_enable = en_n;
		res.lcd_data   = bus_n;
		res.busy_res   = (step_n != clpc_pkg::STEP_IDLE);
		res.ready_res  = done_n;
		res.accepted   = acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= clpc_pkg::STEP_POWER;
			phase_q <= clpc_pkg::PH_SETUP;
			cnt_q   <= '0;
			pend_q  <= '0;
			rs_q    <= 1'b0;
			en_q    <= 1'b0;
			bus_q   <= '0;
			done_q  <= 1'b0;
		end else if (take) begin
			step_q  <= step_n;
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			pend_q  <= pend_n;
			rs_q    <= rs_n;
			en_q    <= en_n;
			bus_q   <= bus_n;
			done_q  <= done_n;
		end
	end

endmodule

// ===== rtl/char_lcd_parallel_controller_unit.sv =====
// Top level of the 8-bit character LCD bus controller.
// One transaction on the item channel is one clock tick (op 0), a character
// write request (op 1) or a restart of initialization (op 2); op 3 is ignored.
// Every accepted item yields exactly one result: the LCD pin levels (RS,
// enable, D0-D7) after that item, busy, ready, and whether a write or restart
// was taken. An item is accepted every cycle while the item channel does not
// stall: the sequencer updates its state in one pass and the result lands in
// an output register, so throughput is one item per cycle; the item channel
// stalls only while the result register is full and the result sink holds
// ready low. After reset the block waits power_up_ticks ticks, sends 0x30
// three times (first, second and command waits), then 0x3C, 0x0E, 0x01 (clear
// wait), 0x05 and 0x18, and raises ready. Each transfer runs setup, enable
// pulse, hold and wait phases; a phase length of zero lasts one tick, and the
// tick counter is DelayBits wide and saturates. A character write is taken
// only when ready and not busy; otherwise it is dropped with accepted low.
// Timing registers (index 0-7: setup, pulse, hold, power-up, first wait,
// second wait, command wait, clear wait) are written through the cfg channel,
// which is always ready; write them only while the block is idle.
module char_lcd_parallel_controller_unit (
	input  logic          clk,
	input  logic          arst_n,
	clpc_item_if.sink     item,
	clpc_result_if.source result,
	clpc_cfg_if.sink      cfg
);

	clpc_pkg::cfg_t    regs;
	clpc_pkg::result_t res_next;
	clpc_pkg::result_t res_q;
	logic              out_valid_q;
	logic              take;

	// Accept whenever the result register is empty or being drained this cycle
	assign item.ready = !out_valid_q || result.ready;
	assign take       = item.valid && item.ready;

	clpc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	clpc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.op        (item.op),
		.char_code (item.char_code),
		.regs      (regs),
		.res       (res_next)
	);

	// Result register: load on each transaction, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_next;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.lcd_rs     = res_q.lcd_rs;
	assign result.lcd_enable = res_q.lcd_enable;
	assign result.lcd_data   = res_q.lcd_data;
	assign result.busy_res   = res_q.busy_res;
	assign result.ready_res  = res_q.ready_res;
	assign result.accepted   = res_q.accepted;

`ifndef SYNTHESIS
	// Data pins are only driven inside a transfer
	a_data_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.lcd_data != 8'd0) |-> result.busy_res)
		else $error("data driven while not busy");

	// A restart is always taken and drops ready
	a_restart_taken: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready && (item.op == clpc_pkg::OP_RESTART)
		|=> result.valid && result.accepted && result.busy_res && !result.ready_res)
		else $error("restart not taken");

	// Ticks never report a taken request
	a_tick_not_taken: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready && (item.op == clpc_pkg::OP_TICK) |=> !result.accepted)
		else $error("tick flagged as accepted");

	// Enable high implies an init or character transfer is running
	a_enable_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.lcd_enable |-> result.busy_res)
		else $error("enable strobe while idle");
`endif

endmodule

// ===== dv/clpc_bus_checker.sv =====
// Checker for the character LCD bus controller: pin and status prediction and result comparison.
module clpc_bus_checker
	import clpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	clpc_item_if        item,
	clpc_result_if      result,
	clpc_cfg_if         cfg,
	output int unsigned pending_results,
	output int          errors
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CmpW-1:0] CountMax = {DelayBits{1'b1}};

	// predicted sequencer state
	cfg_t             timing;
	logic [StepW-1:0] step;
	phase_t           phase;
	logic [CmpW-1:0]  count;
	logic [ByteW-1:0] char_byte;
	logic             rs;
	logic             strobe;
	logic [ByteW-1:0] bus;
	logic             init_done;

	result_t results_due[$];
	result_t got;
	result_t want;
	int      fail_count;

	function automatic logic [ByteW-1:0] strobe_byte();
		logic [ByteW-1:0] b;
		if (step == STEP_CHAR)
			return char_byte;
		case (step)
			STEP_FIRST, STEP_SECOND, STEP_THIRD: b = CMD_WAKE;
			STEP_FUNCTION:                       b = CMD_FUNCTION;
			STEP_DISPLAY:                        b = CMD_DISPLAY;
			STEP_CLEAR:                          b = CMD_CLEAR;
			STEP_ENTRY:                          b = CMD_ENTRY;
			STEP_CURSOR:                         b = CMD_SHIFT;
			default:                             b = '0;
		endcase
		return b;
	endfunction

	function automatic logic [CmpW-1:0] wait_len();
		case (step)
			STEP_FIRST:  return CmpW'(timing.first_wait_ticks);
			STEP_SECOND: return CmpW'(timing.second_wait_ticks);
			STEP_CLEAR:  return CmpW'(timing.clear_wait_ticks);
			default:     return CmpW'(timing.command_wait_ticks);
		endcase
	endfunction

	function automatic void begin_transfer(input logic [StepW-1:0] next_step, input logic rs_v);
		step   = next_step;
		phase  = PH_SETUP;
		count  = '0;
		rs     = rs_v;
		strobe = 1'b0;
		bus    = '0;
	endfunction

	function automatic void advance_phase();
		case (phase)
			PH_SETUP: begin
				phase  = PH_PULSE;
				strobe = 1'b1;
				bus    = strobe_byte();
			end
			PH_PULSE: begin
				phase  = PH_HOLD;
				strobe = 1'b0;
			end
			PH_HOLD: begin
				phase = PH_WAIT;
				bus   = '0;
			end
			default: begin
				if (step == STEP_CHAR || step >= STEP_CURSOR) begin
					if (step == STEP_CURSOR)
						init_done = 1'b1;
					step  = STEP_IDLE;
					phase = PH_SETUP;
				end else begin
					begin_transfer(step + 1'b1, 1'b0);
				end
			end
		endcase
	endfunction

	function automatic void tick_sequencer();
		logic [CmpW-1:0] len;
		if (step == STEP_IDLE || step > STEP_CHAR)
			return;
		if (step == STEP_POWER) begin
			len = CmpW'(timing.power_up_ticks);
		end else begin
			case (phase)
				PH_SETUP: len = CmpW'(timing.setup_ticks);
				PH_PULSE: len = CmpW'(timing.pulse_ticks);
				PH_HOLD:  len = CmpW'(timing.hold_ticks);
				default:  len = wait_len();
			endcase
		end
		// the counter saturates, so clamp lengths it cannot reach
		if (len > CountMax)
			len = CountMax;
		if (count < CountMax)
			count = count + 1'b1;
		if (count >= len) begin
			count = '0;
			if (step == STEP_POWER)
				begin_transfer(STEP_FIRST, 1'b0);
			else
				advance_phase();
		end
	endfunction

	function automatic result_t predict_pins(input logic [OpW-1:0] op_v,
		input logic [ByteW-1:0] code_v);
		result_t r;
		logic    taken;
		taken = 1'b0;
		case (op_v)
			OP_TICK: tick_sequencer();
			OP_CHAR: begin
				if (step == STEP_IDLE && init_done) begin
					char_byte = code_v;
					begin_transfer(STEP_CHAR, 1'b1);
					taken = 1'b1;
				end
			end
			OP_RESTART: begin
				begin_transfer(STEP_POWER, 1'b0);
				init_done = 1'b0;
				taken     = 1'b1;
			end
			default: ;
		endcase
		r.lcd_rs     = rs;
		r.lcd_enable = strobe;
		r.lcd_data   = bus;
		r.busy_res   = (step != STEP_IDLE);
		r.ready_res  = init_done;
		r.accepted   = taken;
		return r;
	endfunction

	function automatic void apply_write(input logic [CfgIdxW-1:0] idx,
		input logic [CfgDataW-1:0] data);
		case (idx)
			REG_SETUP:        timing.setup_ticks        = data[TimeW-1:0];
			REG_PULSE:        timing.pulse_ticks        = data[TimeW-1:0];
			REG_HOLD:         timing.hold_ticks         = data[TimeW-1:0];
			REG_POWER_UP:     timing.power_up_ticks     = data[WaitW-1:0];
			REG_FIRST_WAIT:   timing.first_wait_ticks   = data[WaitW-1:0];
			REG_SECOND_WAIT:  timing.second_wait_ticks  = data[WaitW-1:0];
			REG_COMMAND_WAIT: timing.command_wait_ticks = data[WaitW-1:0];
			REG_CLEAR_WAIT:   timing.clear_wait_ticks   = data[WaitW-1:0];
			default: ;
		endcase
	endfunction

	task automatic check_field(input string field, input logic [ByteW-1:0] want_v,
		input logic [ByteW-1:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s expected %0h, got %0h", $realtime, field, want_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing.setup_ticks        = 8'd1;
			timing.pulse_ticks        = 8'd2;
			timing.hold_ticks         = 8'd1;
			timing.power_up_ticks     = 20'd240000;
			timing.first_wait_ticks   = 20'd65600;
			timing.second_wait_ticks  = 20'd1600;
			timing.command_wait_ticks = 20'd624;
			timing.clear_wait_ticks   = 20'd25320;
			begin_transfer(STEP_POWER, 1'b0);
			char_byte  = '0;
			init_done  = 1'b0;
			fail_count = 0;
			results_due.delete();
			pending_results <= 0;
			errors          <= 0;
		end else begin
			if (result.valid && result.ready) begin
				got.lcd_rs     = result.lcd_rs;
				got.lcd_enable = result.lcd_enable;
				got.lcd_data   = result.lcd_data;
				got.busy_res   = result.busy_res;
				got.ready_res  = result.ready_res;
				got.accepted   = result.accepted;
				if (results_due.size() == 0) begin
					$display("%0t: result with nothing expected, got %0h", $realtime, got);
					fail_count++;
				end else begin
					want = results_due.pop_front();
					check_field("lcd_rs", ByteW'(want.lcd_rs), ByteW'(got.lcd_rs));
					check_field("lcd_enable", ByteW'(want.lcd_enable), ByteW'(got.lcd_enable));
					check_field("lcd_data", want.lcd_data, got.lcd_data);
					check_field("busy_res", ByteW'(want.busy_res), ByteW'(got.busy_res));
					check_field("ready_res", ByteW'(want.ready_res), ByteW'(got.ready_res));
					check_field("accepted", ByteW'(want.accepted), ByteW'(got.accepted));
				end
			end
			// an item taken at the same edge as a write still sees the old timing
			if (item.valid && item.ready)
				results_due.push_back(predict_pins(item.op, item.char_code));
			if (cfg.valid && cfg.ready)
				apply_write(cfg.index, cfg.data);
			pending_results <= results_due.size();
			errors          <= fail_count;
		end
	end

endmodule

// ===== dv/tb_char_lcd_parallel_controller_unit.sv =====
// Testbench top of the character LCD bus controller: stimulus, handshake pressure and verdict.
module tb_char_lcd_parallel_controller_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import clpc_pkg::*;

	// op code 3 is undefined and must be ignored by the block
	localparam logic [OpW-1:0] OP_UNUSED = 2'd3;
	localparam int RunLimit = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        sink_ready = 1'b0;
	int          src_idle_pct = 0;
	int          dst_idle_pct = 0;
	int unsigned pending_results;
	int          errors;
	int          cycle_count = 0;

	clpc_item_if   item_ch();
	clpc_result_if result_ch();
	clpc_cfg_if    cfg_ch();

	char_lcd_parallel_controller_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	clpc_bus_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.item            (item_ch),
		.result          (result_ch),
		.cfg             (cfg_ch),
		.pending_results (pending_results),
		.errors          (errors)
	);

	always #5 clk = ~clk;

	// Receiver side: drop ready at random at the rate of the current phase.
	always @(posedge clk) begin
		sink_ready <= ($urandom_range(99) >= dst_idle_pct);
	end

	assign result_ch.ready = sink_ready;

	// Watchdog: end the run if the block stops answering.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RunLimit) begin
			$display("tb_char_lcd_parallel_controller_unit: errors");
			$finish;
		end
	end

	// Offer one item, with random idle cycles ahead of it, and return at the
	// edge that takes it. Valid stays high so back-to-back items need no gap.
	task automatic send_item(input logic [OpW-1:0] op_v, input logic [ByteW-1:0] code_v);
		while ($urandom_range(99) < src_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.op        <= op_v;
		item_ch.char_code <= code_v;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_item(OP_TICK, ByteW'($urandom_range(255)));
	endtask

	// Hold the sender until every predicted result has come back.
	task automatic wait_for_results();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
	endtask

	// Write one register; valid is left high for a following write.
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic program_timing(input cfg_t t);
		write_reg(REG_SETUP, CfgDataW'(t.setup_ticks));
		write_reg(REG_PULSE, CfgDataW'(t.pulse_ticks));
		write_reg(REG_HOLD, CfgDataW'(t.hold_ticks));
		write_reg(REG_POWER_UP, t.power_up_ticks);
		write_reg(REG_FIRST_WAIT, t.first_wait_ticks);
		write_reg(REG_SECOND_WAIT, t.second_wait_ticks);
		write_reg(REG_COMMAND_WAIT, t.command_wait_ticks);
		write_reg(REG_CLEAR_WAIT, t.clear_wait_ticks);
		cfg_ch.valid <= 1'b0;
	endtask

	// Short random timings keep a full init sequence short.
	function automatic cfg_t random_timing();
		cfg_t t;
		t.setup_ticks        = TimeW'($urandom_range(3));
		t.pulse_ticks        = TimeW'($urandom_range(3, 1));
		t.hold_ticks         = TimeW'($urandom_range(3));
		t.power_up_ticks     = WaitW'($urandom_range(4));
		t.first_wait_ticks   = WaitW'($urandom_range(4));
		t.second_wait_ticks  = WaitW'($urandom_range(4));
		t.command_wait_ticks = WaitW'($urandom_range(4));
		t.clear_wait_ticks   = WaitW'($urandom_range(4));
		return t;
	endfunction

	// Mostly ticks so init and transfers run to completion; character writes
	// land both while busy and while idle; restarts are rare enough that the
	// sequencer still reaches ready between them.
	task automatic run_random(input int n);
		int pick;
		repeat (n) begin
			pick = $urandom_range(99);
			if (pick < 72)
				send_item(OP_TICK, ByteW'($urandom_range(255)));
			else if (pick < 93)
				send_item(OP_CHAR, ByteW'($urandom_range(255)));
			else if (pick < 96)
				send_item(OP_UNUSED, ByteW'($urandom_range(255)));
			else if (pick < 97)
				send_item(OP_RESTART, ByteW'($urandom_range(255)));
			else
				send_item(OP_TICK, ByteW'($urandom_range(255)));
		end
	endtask

	cfg_t quick_timing;
	cfg_t slow_strobe;
	cfg_t max_waits;

	initial begin
		// every block input known from time zero
		item_ch.valid     <= 1'b0;
		item_ch.op        <= OP_TICK;
		item_ch.char_code <= '0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.index      <= REG_SETUP;
		cfg_ch.data       <= '0;

		// shortest strobe phases (zero setup and hold, one-tick pulse)
		quick_timing = '{setup_ticks: 8'd0, pulse_ticks: 8'd1, hold_ticks: 8'd0,
			power_up_ticks: 20'd2, first_wait_ticks: 20'd1, second_wait_ticks: 20'd0,
			command_wait_ticks: 20'd1, clear_wait_ticks: 20'd3};
		// longest strobe phases with zero waits
		slow_strobe = '{setup_ticks: 8'hFF, pulse_ticks: 8'hFF, hold_ticks: 8'hFF,
			power_up_ticks: 20'd0, first_wait_ticks: 20'd0, second_wait_ticks: 20'd0,
			command_wait_ticks: 20'd0, clear_wait_ticks: 20'd0};
		// every wait at its top value; the power-up wait never ends in this run
		max_waits = '{setup_ticks: 8'hFF, pulse_ticks: 8'hFF, hold_ticks: 8'hFF,
			power_up_ticks: 20'hFFFFF, first_wait_ticks: 20'hFFFFF,
			second_wait_ticks: 20'hFFFFF, command_wait_ticks: 20'hFFFFF,
			clear_wait_ticks: 20'hFFFFF};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Phase 1: sender mostly busy, receiver stalls often.
		src_idle_pct = 12;
		dst_idle_pct = 74;
		program_timing(quick_timing);

		// directed: write before ready, unused op, restart during power-up wait
		send_item(OP_CHAR, 8'h41);
		send_item(OP_UNUSED, 8'hFF);
		send_item(OP_RESTART, 8'h00);
		// run the full init sequence to ready
		send_ticks(45);
		// lowest code taken, then a write while busy is rejected
		send_item(OP_CHAR, 8'h00);
		send_item(OP_CHAR, 8'hFF);
		send_ticks(6);
		// highest code, then restart in the middle of its transfer
		send_item(OP_CHAR, 8'hFF);
		send_ticks(2);
		send_item(OP_RESTART, 8'h5A);
		send_item(OP_UNUSED, 8'h00);
		send_ticks(45);
		send_item(OP_CHAR, 8'h80);
		send_ticks(5);
		// restart from idle with ready set
		send_item(OP_RESTART, 8'hA5);
		send_ticks(3);

		run_random(90);

		// Phase 2: sender idles often, receiver rarely stalls.
		wait_for_results();
		src_idle_pct = 74;
		dst_idle_pct = 12;
		program_timing(random_timing());
		send_item(OP_RESTART, ByteW'($urandom_range(255)));
		run_random(50);
		// hold the sender until the block has drained
		wait_for_results();
		run_random(50);

		// Phase 3: no idling on either side; longest strobe phases.
		wait_for_results();
		src_idle_pct = 0;
		dst_idle_pct = 0;
		program_timing(slow_strobe);
		send_item(OP_RESTART, ByteW'($urandom_range(255)));
		repeat (120)
			send_item(($urandom_range(9) == 0) ? OP_CHAR : OP_TICK, ByteW'($urandom_range(255)));

		// all waits at their top value, then leave them behind with new timings
		wait_for_results();
		program_timing(max_waits);
		send_item(OP_RESTART, ByteW'($urandom_range(255)));
		send_ticks(20);

		wait_for_results();
		program_timing(random_timing());
		send_item(OP_RESTART, ByteW'($urandom_range(255)));
		run_random(60);

		// drain, then allow the output register to settle
		wait_for_results();
		repeat (4) @(posedge clk);

		if (errors == 0)
			$display("tb_char_lcd_parallel_controller_unit: clean");
		else
			$display("tb_char_lcd_parallel_controller_unit: errors");
		$finish;
	end

endmodule
